// ----- design/bfra_pkg.sv -----
// types, codes and table entry helpers shared by the region allocator
package bfra_pkg;

    localparam int SIZE_W  = 21;
    localparam int OFS_W   = 20;
    localparam int ENTRY_W = SIZE_W + 2;
    localparam int FREE_BIT = SIZE_W;
    localparam int RSV_BIT  = SIZE_W + 1;
    localparam int USED_W   = 7;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int RESERVED_SLOTS = 2;
    localparam logic [SIZE_W-1:0] POOL_LIMIT = SIZE_W'(1) << (SIZE_W - 1);

    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_GET   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_OFFSET = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_INIT_ERR   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES0_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RES0_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RES1_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RES1_SIZE   = 3'd4;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SIZE_W-1:0] request_size;
        logic [OFS_W-1:0]  block_offset;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFS_W-1:0]    block_start;
        logic [SIZE_W-1:0]   block_bytes;
        logic [USED_W-1:0]   used_blocks;
        logic [SIZE_W-1:0]   used_bytes;
        logic [SIZE_W-1:0]   free_bytes;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT_BASE, S_WIN, S_SCAN_RD, S_SCAN_EV,
        S_CARVE, S_CARVE2, S_CARVE3, S_ALLOC_EV, S_FREE_EV,
        S_NEXT_EV, S_MERGE, S_SHD_RD, S_SHD_WR,
        S_SHU_START, S_SHU_RD, S_SHU_WR, S_SHU_FIN, S_DONE
    } state_t;

    function automatic logic [SIZE_W-1:0] ent_size(input logic [ENTRY_W-1:0] e);
        return e[SIZE_W-1:0];
    endfunction

    function automatic logic ent_free(input logic [ENTRY_W-1:0] e);
        return e[FREE_BIT];
    endfunction

    function automatic logic ent_rsv(input logic [ENTRY_W-1:0] e);
        return e[RSV_BIT];
    endfunction

    function automatic logic [ENTRY_W-1:0] mk_entry(input logic rsv, input logic fr,
                                                    input logic [SIZE_W-1:0] sz);
        return {rsv, fr, sz};
    endfunction

endpackage

// ----- design/bfra_ram.sv -----
// generic simple dual-port ram with registered read
module bfra_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/best_fit_region_allocator_unit.sv -----
// best-fit region allocator: region table in ram, sequencer for scans and shifts
// One item is worked at a time; s_ready is high only while the sequencer is idle. The region
// table sits in a ram with registered read, so every table walk reads an entry and then acts
// on it, and opening or closing a gap in the table moves each later entry by a read and a
// write. Alloc at worst does a full scan, then opens a gap near the front; free stops its
// search at the block, and only the entries after it move down; get size only searches. Init
// works on a table that then holds no more than five regions. The region count is at most
// MAX_REGIONS. A finished result waits in an output register while the next item starts.
// There is no clearing pass after reset: only entries below the region count are ever read.
module best_fit_region_allocator_unit
    import bfra_pkg::*;
#(
    parameter int MAX_REGIONS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  req_t                 s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rsp_t                 m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

    // configuration
    logic [SIZE_W-1:0] pool_size_reg;
    logic [OFS_W-1:0]  res_start_reg [RESERVED_SLOTS];
    logic [SIZE_W-1:0] res_size_reg  [RESERVED_SLOTS];

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [1:0]         mode_reg, mode_next;
    logic [OFS_W-1:0]   key_reg, key_next;
    logic [SIZE_W:0]    size_reg, size_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   acnt_reg, acnt_next;
    logic [SIZE_W-1:0]  abytes_reg, abytes_next;
    logic [SIZE_W-1:0]  fbytes_reg, fbytes_next;
    logic [SIZE_W-1:0]  avail_reg, avail_next;
    logic [1:0]         win_reg, win_next;
    logic [CNT_W-1:0]   scan_i_reg, scan_i_next;
    logic [SIZE_W-1:0]  cur_reg, cur_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [SIZE_W-1:0]  base_reg, base_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [ENTRY_W-1:0] prev_reg, prev_next;
    logic [ENTRY_W-1:0] nxt_reg, nxt_next;
    logic               pfree_reg, pfree_next;
    logic               nfree_reg, nfree_next;
    logic [SIZE_W-1:0]  left_reg, left_next;
    logic [SIZE_W-1:0]  rsize_reg, rsize_next;
    logic [CNT_W-1:0]   cidx_reg, cidx_next;
    logic [CNT_W-1:0]   sh_j_reg, sh_j_next;
    logic [CNT_W-1:0]   sh_p_reg, sh_p_next;
    logic [1:0]         sh_k_reg, sh_k_next;
    logic [ENTRY_W-1:0] sh_val_reg, sh_val_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OFS_W-1:0]   bstart_reg, bstart_next;
    logic [SIZE_W-1:0]  bbytes_reg, bbytes_next;
    logic               m_valid_reg, m_valid_next;
    rsp_t               m_data_reg, m_data_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    // derived values
    logic [SIZE_W-1:0] sz21, scan_rs, scan_left, ent_rs, carve_gap, merge_total;
    logic [SIZE_W:0]   scan_end;
    logic [CNT_W-1:0]  merge_tgt;
    logic [1:0]        merge_k;
    logic [CNT_W:0]    shd_src;
    logic [SIZE_W:0]   round_size;
    logic [OFS_W-1:0]  win_start;
    logic [SIZE_W-1:0] win_size;

    assign sz21        = size_reg[SIZE_W-1:0];
    assign scan_rs     = ent_size(ram_rdata);
    assign scan_end    = {1'b0, cur_reg} + {1'b0, scan_rs};
    assign scan_left   = scan_rs - sz21;
    assign ent_rs      = ent_size(entry_reg);
    assign carve_gap   = {1'b0, key_reg} - base_reg;
    assign merge_total = ent_rs + (pfree_reg ? ent_size(prev_reg) : '0)
                       + (nfree_reg ? ent_size(nxt_reg) : '0);
    assign merge_tgt   = pfree_reg ? idx_reg - CNT_W'(1) : idx_reg;
    assign merge_k     = {1'b0, pfree_reg} + {1'b0, nfree_reg};
    assign shd_src     = {1'b0, sh_j_reg} + (CNT_W + 1)'(sh_k_reg);
    // round up to four, zero becomes four
    assign round_size  = (({1'b0, s_data.request_size} + (SIZE_W + 1)'(3)) &
                          ~(SIZE_W + 1)'(3)) == '0 ? (SIZE_W + 1)'(4) :
                         (({1'b0, s_data.request_size} + (SIZE_W + 1)'(3)) &
                          ~(SIZE_W + 1)'(3));
    assign win_start   = res_start_reg[win_reg[0]];
    assign win_size    = res_size_reg[win_reg[0]];

    bfra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg    <= '0;
            res_start_reg[0] <= '0;
            res_start_reg[1] <= '0;
            res_size_reg[0]  <= '0;
            res_size_reg[1]  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_POOL_SIZE:  pool_size_reg    <= cfg_wdata;
                CFG_RES0_START: res_start_reg[0] <= cfg_wdata[OFS_W-1:0];
                CFG_RES0_SIZE:  res_size_reg[0]  <= cfg_wdata;
                CFG_RES1_START: res_start_reg[1] <= cfg_wdata[OFS_W-1:0];
                CFG_RES1_SIZE:  res_size_reg[1]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_DONE;
            count_reg   <= '0;
            acnt_reg    <= '0;
            abytes_reg  <= '0;
            fbytes_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            count_reg   <= count_next;
            acnt_reg    <= acnt_next;
            abytes_reg  <= abytes_next;
            fbytes_reg  <= fbytes_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        size_reg   <= size_next;
        avail_reg  <= avail_next;
        win_reg    <= win_next;
        scan_i_reg <= scan_i_next;
        cur_reg    <= cur_next;
        found_reg  <= found_next;
        idx_reg    <= idx_next;
        base_reg   <= base_next;
        entry_reg  <= entry_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        pfree_reg  <= pfree_next;
        nfree_reg  <= nfree_next;
        left_reg   <= left_next;
        rsize_reg  <= rsize_next;
        cidx_reg   <= cidx_next;
        sh_j_reg   <= sh_j_next;
        sh_p_reg   <= sh_p_next;
        sh_k_reg   <= sh_k_next;
        sh_val_reg <= sh_val_next;
        status_reg <= status_next;
        bstart_reg <= bstart_next;
        bbytes_reg <= bbytes_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        size_next    = size_reg;
        count_next   = count_reg;
        acnt_next    = acnt_reg;
        abytes_next  = abytes_reg;
        fbytes_next  = fbytes_reg;
        avail_next   = avail_reg;
        win_next     = win_reg;
        scan_i_next  = scan_i_reg;
        cur_next     = cur_reg;
        found_next   = found_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        entry_next   = entry_reg;
        prev_next    = prev_reg;
        nxt_next     = nxt_reg;
        pfree_next   = pfree_reg;
        nfree_next   = nfree_reg;
        left_next    = left_reg;
        rsize_next   = rsize_reg;
        cidx_next    = cidx_reg;
        sh_j_next    = sh_j_reg;
        sh_p_next    = sh_p_reg;
        sh_k_next    = sh_k_reg;
        sh_val_next  = sh_val_reg;
        status_next  = status_reg;
        bstart_next  = bstart_reg;
        bbytes_next  = bbytes_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_data.mode;
                    key_next    = s_data.block_offset;
                    status_next = STAT_OK;
                    bstart_next = '0;
                    bbytes_next = '0;
                    prev_next   = '0;
                    found_next  = 1'b0;
                    scan_i_next = '0;
                    cur_next    = '0;
                    left_next   = '0;
                    case (s_data.mode)
                        MODE_INIT: begin
                            count_next  = '0;
                            acnt_next   = '0;
                            abytes_next = '0;
                            fbytes_next = '0;
                            if (pool_size_reg == '0 || pool_size_reg[1:0] != 2'b00 ||
                                pool_size_reg > POOL_LIMIT) begin
                                status_next = STAT_INIT_ERR;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_INIT_BASE;
                            end
                        end
                        MODE_ALLOC: begin
                            size_next = round_size;
                            if (round_size > {1'b0, fbytes_reg}) begin
                                status_next = STAT_NO_SPACE;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default: begin
                            status_next = STAT_BAD_OFFSET;
                            if (count_reg == '0 || s_data.block_offset[1:0] != 2'b00) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                    endcase
                end
            end

            S_INIT_BASE: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = mk_entry(1'b0, 1'b1, pool_size_reg);
                count_next = CNT_W'(1);
                avail_next = pool_size_reg;
                win_next   = '0;
                state_next = S_WIN;
            end

            S_WIN: begin
                if (win_reg == 2'(RESERVED_SLOTS)) begin
                    fbytes_next = avail_reg;
                    state_next  = S_DONE;
                end else if (win_size == '0) begin
                    win_next = win_reg + 2'd1;
                end else if (win_start[1:0] != 2'b00 || win_size[1:0] != 2'b00) begin
                    count_next  = '0;
                    status_next = STAT_INIT_ERR;
                    state_next  = S_DONE;
                end else begin
                    key_next    = win_start;
                    size_next   = {1'b0, win_size};
                    scan_i_next = '0;
                    cur_next    = '0;
                    found_next  = 1'b0;
                    state_next  = S_SCAN_RD;
                end
            end

            S_SCAN_RD: begin
                if (scan_i_reg >= count_reg) begin
                    case (mode_reg)
                        MODE_INIT:  state_next = S_CARVE;
                        MODE_ALLOC: state_next = S_ALLOC_EV;
                        default:    state_next = S_FREE_EV;
                    endcase
                end else begin
                    ram_raddr  = scan_i_reg[IDX_W-1:0];
                    state_next = S_SCAN_EV;
                end
            end

            S_SCAN_EV: begin
                if (mode_reg == MODE_ALLOC) begin
                    cur_next    = scan_end[SIZE_W-1:0];
                    scan_i_next = scan_i_reg + CNT_W'(1);
                    state_next  = S_SCAN_RD;
                    if (ent_free(ram_rdata) && scan_rs >= sz21 &&
                        (!found_reg || scan_left < left_reg)) begin
                        found_next = 1'b1;
                        idx_next   = scan_i_reg;
                        left_next  = scan_left;
                        base_next  = cur_reg;
                        // exact fit ends the search
                        if (scan_left == '0) begin
                            state_next = S_ALLOC_EV;
                        end
                    end
                end else begin
                    if ({2'b00, key_reg} < scan_end) begin
                        found_next = 1'b1;
                        idx_next   = scan_i_reg;
                        base_next  = cur_reg;
                        entry_next = ram_rdata;
                        case (mode_reg)
                            MODE_INIT: state_next = S_CARVE;
                            default:   state_next = S_FREE_EV;
                        endcase
                    end else begin
                        prev_next   = ram_rdata;
                        cur_next    = scan_end[SIZE_W-1:0];
                        scan_i_next = scan_i_reg + CNT_W'(1);
                        state_next  = S_SCAN_RD;
                    end
                end
            end

            S_CARVE: begin
                if (!found_reg || !ent_free(entry_reg)) begin
                    count_next  = '0;
                    status_next = STAT_INIT_ERR;
                    state_next  = S_DONE;
                end else if ({1'b0, key_reg} > base_reg) begin
                    if (count_reg >= MAX_CNT) begin
                        count_next  = '0;
                        status_next = STAT_TABLE_FULL;
                        state_next  = S_DONE;
                    end else begin
                        // free head before the window
                        ram_we      = 1'b1;
                        ram_waddr   = idx_reg[IDX_W-1:0];
                        ram_wdata   = mk_entry(1'b0, 1'b1, carve_gap);
                        rsize_next  = ent_rs - carve_gap;
                        cidx_next   = idx_reg + CNT_W'(1);
                        sh_p_next   = idx_reg + CNT_W'(1);
                        sh_val_next = mk_entry(1'b0, 1'b1, ent_rs - carve_gap);
                        ret_next    = S_CARVE2;
                        state_next  = S_SHU_START;
                    end
                end else begin
                    rsize_next = ent_rs;
                    cidx_next  = idx_reg;
                    state_next = S_CARVE2;
                end
            end

            S_CARVE2: begin
                if (sz21 > rsize_reg) begin
                    count_next  = '0;
                    status_next = STAT_INIT_ERR;
                    state_next  = S_DONE;
                end else if (sz21 < rsize_reg && count_reg >= MAX_CNT) begin
                    count_next  = '0;
                    status_next = STAT_TABLE_FULL;
                    state_next  = S_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = cidx_reg[IDX_W-1:0];
                    ram_wdata = mk_entry(1'b1, 1'b0, sz21);
                    if (sz21 < rsize_reg) begin
                        sh_p_next   = cidx_reg + CNT_W'(1);
                        sh_val_next = mk_entry(1'b0, 1'b1, rsize_reg - sz21);
                        ret_next    = S_CARVE3;
                        state_next  = S_SHU_START;
                    end else begin
                        state_next = S_CARVE3;
                    end
                end
            end

            S_CARVE3: begin
                if (avail_reg < sz21) begin
                    count_next  = '0;
                    status_next = STAT_INIT_ERR;
                    state_next  = S_DONE;
                end else begin
                    avail_next = avail_reg - sz21;
                    win_next   = win_reg + 2'd1;
                    state_next = S_WIN;
                end
            end

            S_ALLOC_EV: begin
                state_next = S_DONE;
                if (!found_reg) begin
                    status_next = STAT_NO_SPACE;
                end else if (left_reg != '0 && count_reg >= MAX_CNT) begin
                    status_next = STAT_TABLE_FULL;
                end else begin
                    acnt_next   = acnt_reg + CNT_W'(1);
                    abytes_next = abytes_reg + sz21;
                    fbytes_next = fbytes_reg - sz21;
                    ram_we      = 1'b1;
                    ram_waddr   = idx_reg[IDX_W-1:0];
                    ram_wdata   = mk_entry(1'b0, 1'b0, sz21);
                    bstart_next = base_reg[OFS_W-1:0];
                    bbytes_next = sz21;
                    if (left_reg != '0) begin
                        sh_p_next   = idx_reg + CNT_W'(1);
                        sh_val_next = mk_entry(1'b0, 1'b1, left_reg);
                        ret_next    = S_DONE;
                        state_next  = S_SHU_START;
                    end
                end
            end

            S_FREE_EV: begin
                state_next = S_DONE;
                if (found_reg && base_reg == {1'b0, key_reg} &&
                    !ent_free(entry_reg) && !ent_rsv(entry_reg)) begin
                    if (mode_reg == MODE_GET) begin
                        status_next = STAT_OK;
                        bbytes_next = ent_rs;
                    end else if (acnt_reg != '0 && abytes_reg >= ent_rs) begin
                        status_next = STAT_OK;
                        acnt_next   = acnt_reg - CNT_W'(1);
                        abytes_next = abytes_reg - ent_rs;
                        fbytes_next = fbytes_reg + ent_rs;
                        pfree_next  = idx_reg != '0 && ent_free(prev_reg);
                        if (idx_reg + CNT_W'(1) < count_reg) begin
                            ram_raddr  = IDX_W'(idx_reg + CNT_W'(1));
                            state_next = S_NEXT_EV;
                        end else begin
                            nfree_next = 1'b0;
                            state_next = S_MERGE;
                        end
                    end
                end
            end

            S_NEXT_EV: begin
                nxt_next   = ram_rdata;
                nfree_next = ent_free(ram_rdata);
                state_next = S_MERGE;
            end

            S_MERGE: begin
                ram_we    = 1'b1;
                ram_waddr = merge_tgt[IDX_W-1:0];
                ram_wdata = mk_entry(1'b0, 1'b1, merge_total);
                if (merge_k == 2'd0) begin
                    state_next = S_DONE;
                end else begin
                    sh_j_next  = merge_tgt + CNT_W'(1);
                    sh_k_next  = merge_k;
                    state_next = S_SHD_RD;
                end
            end

            // close the gap: entries move down by one or two places
            S_SHD_RD: begin
                if (shd_src >= {1'b0, count_reg}) begin
                    count_next = count_reg - CNT_W'(sh_k_reg);
                    state_next = S_DONE;
                end else begin
                    ram_raddr  = shd_src[IDX_W-1:0];
                    state_next = S_SHD_WR;
                end
            end

            S_SHD_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = sh_j_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                sh_j_next  = sh_j_reg + CNT_W'(1);
                state_next = S_SHD_RD;
            end

            // open a gap at sh_p, walking down from the last entry
            S_SHU_START: begin
                if (sh_p_reg == count_reg) begin
                    state_next = S_SHU_FIN;
                end else begin
                    sh_j_next  = count_reg - CNT_W'(1);
                    state_next = S_SHU_RD;
                end
            end

            S_SHU_RD: begin
                ram_raddr  = sh_j_reg[IDX_W-1:0];
                state_next = S_SHU_WR;
            end

            S_SHU_WR: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(sh_j_reg + CNT_W'(1));
                ram_wdata = ram_rdata;
                if (sh_j_reg == sh_p_reg) begin
                    state_next = S_SHU_FIN;
                end else begin
                    sh_j_next  = sh_j_reg - CNT_W'(1);
                    state_next = S_SHU_RD;
                end
            end

            S_SHU_FIN: begin
                ram_we     = 1'b1;
                ram_waddr  = sh_p_reg[IDX_W-1:0];
                ram_wdata  = sh_val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ret_reg;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.status      = status_reg;
                    m_data_next.block_start = bstart_reg;
                    m_data_next.block_bytes = bbytes_reg;
                    m_data_next.used_blocks = USED_W'(acnt_reg);
                    m_data_next.used_bytes  = abytes_reg;
                    m_data_next.free_bytes  = fbytes_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the best-fit region allocator
`timescale 1ns / 100ps

module testbench;
    import bfra_pkg::*;

    localparam int NUM_REGIONS = 64;
    localparam int DRAIN_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 4000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    best_fit_region_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the region table and counters
    int unsigned rgn_size[NUM_REGIONS];
    bit rgn_free[NUM_REGIONS];
    bit rgn_rsv[NUM_REGIONS];
    int unsigned rgn_count, blk_count, used_total, free_total, usable_total;
    int unsigned cfg_shadow[5];
    int unsigned live_starts[$];

    req_t pending_reqs[$];
    rsp_t expected_rsp[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int status_seen[5];
    int peak_regions = 0;
    longint cycles = 0;

    function automatic int locate_region(input int unsigned ofs, output int unsigned base);
        int unsigned cur;
        cur = 0;
        base = 0;
        for (int i = 0; i < rgn_count; i++) begin
            if (ofs >= cur && ofs < cur + rgn_size[i]) begin
                base = cur;
                return i;
            end
            cur += rgn_size[i];
        end
        return -1;
    endfunction

    function automatic void insert_region(input int unsigned idx, input int unsigned sz,
                                          input bit fr, input bit rs);
        if (rgn_count >= NUM_REGIONS || idx > rgn_count) return;
        for (int j = rgn_count; j > idx; j--) begin
            rgn_size[j] = rgn_size[j-1];
            rgn_free[j] = rgn_free[j-1];
            rgn_rsv[j] = rgn_rsv[j-1];
        end
        rgn_size[idx] = sz;
        rgn_free[idx] = fr;
        rgn_rsv[idx] = rs;
        rgn_count++;
        if (rgn_count > peak_regions) peak_regions = rgn_count;
    endfunction

    function automatic void remove_region(input int unsigned idx);
        if (idx >= rgn_count) return;
        for (int j = idx; j + 1 < rgn_count; j++) begin
            rgn_size[j] = rgn_size[j+1];
            rgn_free[j] = rgn_free[j+1];
            rgn_rsv[j] = rgn_rsv[j+1];
        end
        rgn_count--;
        rgn_size[rgn_count] = 0;
        rgn_free[rgn_count] = 0;
        rgn_rsv[rgn_count] = 0;
    endfunction

    function automatic void clear_pool();
        rgn_count = 0;
        blk_count = 0;
        used_total = 0;
        free_total = 0;
        usable_total = 0;
        live_starts.delete();
    endfunction

    function automatic logic [STATUS_W-1:0] carve_window(input int unsigned st,
                                                         input int unsigned sz);
        int unsigned base, rsize, idx;
        int found;
        found = locate_region(st, base);
        if (found < 0) return STAT_INIT_ERR;
        idx = found;
        if (!rgn_free[idx]) return STAT_INIT_ERR;
        rsize = rgn_size[idx];
        if (st > base) begin
            if (rgn_count >= NUM_REGIONS) return STAT_TABLE_FULL;
            rgn_size[idx] = st - base;
            rsize -= st - base;
            idx++;
            insert_region(idx, rsize, 1'b1, 1'b0);
        end
        if (sz > rsize) return STAT_INIT_ERR;
        if (sz < rsize && rgn_count >= NUM_REGIONS) return STAT_TABLE_FULL;
        rgn_size[idx] = sz;
        rgn_free[idx] = 1'b0;
        rgn_rsv[idx] = 1'b1;
        if (sz < rsize) insert_region(idx + 1, rsize - sz, 1'b1, 1'b0);
        return STAT_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] build_pool();
        int unsigned pool, avail, st, sz;
        logic [STATUS_W-1:0] r;
        clear_pool();
        pool = cfg_shadow[CFG_POOL_SIZE];
        if (pool == 0 || (pool & 3) != 0 || pool > (1 << 20)) return STAT_INIT_ERR;
        avail = pool;
        rgn_size[0] = pool;
        rgn_free[0] = 1'b1;
        rgn_rsv[0] = 1'b0;
        rgn_count = 1;
        for (int i = 0; i < RESERVED_SLOTS; i++) begin
            st = cfg_shadow[1 + 2*i];
            sz = cfg_shadow[2 + 2*i];
            if (sz == 0) continue;
            if ((st & 3) != 0 || (sz & 3) != 0) begin
                clear_pool();
                return STAT_INIT_ERR;
            end
            r = carve_window(st, sz);
            if (r == STAT_OK && avail < sz) r = STAT_INIT_ERR;
            if (r != STAT_OK) begin
                clear_pool();
                return r;
            end
            avail -= sz;
        end
        usable_total = avail;
        free_total = avail;
        return STAT_OK;
    endfunction

    function automatic rsp_t predict_allocator_response(input req_t rq);
        rsp_t rs;
        int unsigned size, best_left, best_ofs, cur, base, sz, idx, ofs;
        int best, found;
        rs = '0;
        case (rq.mode)
            MODE_INIT: begin
                rs.status = build_pool();
            end
            MODE_ALLOC: begin
                size = (int'(rq.request_size) + 3) & 32'hFFFF_FFFC;
                if (size == 0) size = 4;
                best = -1;
                best_left = 0;
                best_ofs = 0;
                cur = 0;
                if (size > free_total) begin
                    rs.status = STAT_NO_SPACE;
                end else begin
                    for (int i = 0; i < rgn_count; i++) begin
                        if (rgn_free[i] && rgn_size[i] >= size) begin
                            if (best < 0 || rgn_size[i] - size < best_left) begin
                                best = i;
                                best_left = rgn_size[i] - size;
                                best_ofs = cur;
                                if (best_left == 0) break;
                            end
                        end
                        cur += rgn_size[i];
                    end
                    if (best < 0) begin
                        rs.status = STAT_NO_SPACE;
                    end else if (best_left != 0 && rgn_count >= NUM_REGIONS) begin
                        rs.status = STAT_TABLE_FULL;
                    end else begin
                        rs.status = STAT_OK;
                        blk_count++;
                        used_total += size;
                        free_total -= size;
                        rgn_size[best] = size;
                        rgn_free[best] = 1'b0;
                        rgn_rsv[best] = 1'b0;
                        if (best_left != 0) insert_region(best + 1, best_left, 1'b1, 1'b0);
                        live_starts.push_back(best_ofs);
                        rs.block_start = best_ofs;
                        rs.block_bytes = size;
                    end
                end
            end
            default: begin
                rs.status = STAT_BAD_OFFSET;
                ofs = rq.block_offset;
                found = -1;
                base = 0;
                if (rgn_count != 0 && (ofs & 3) == 0) found = locate_region(ofs, base);
                if (found >= 0 && base == ofs && !rgn_free[found] && !rgn_rsv[found]) begin
                    sz = rgn_size[found];
                    if (rq.mode == MODE_GET) begin
                        rs.status = STAT_OK;
                        rs.block_bytes = sz;
                    end else if (blk_count != 0 && used_total >= sz) begin
                        idx = found;
                        rs.status = STAT_OK;
                        blk_count--;
                        used_total -= sz;
                        free_total += sz;
                        rgn_free[idx] = 1'b1;
                        foreach (live_starts[k])
                            if (live_starts[k] == ofs) begin
                                live_starts.delete(k);
                                break;
                            end
                        // fold into a free left neighbour, then a free right one
                        if (idx > 0 && rgn_free[idx-1]) begin
                            sz += rgn_size[idx-1];
                            rgn_size[idx-1] = sz;
                            remove_region(idx);
                            idx--;
                        end
                        if (idx + 1 < rgn_count && rgn_free[idx+1]) begin
                            rgn_size[idx] = rgn_size[idx+1] + sz;
                            remove_region(idx + 1);
                        end
                    end
                end
            end
        endcase
        rs.used_blocks = blk_count[USED_W-1:0];
        rs.used_bytes = used_total[SIZE_W-1:0];
        rs.free_bytes = free_total[SIZE_W-1:0];
        return rs;
    endfunction

    // driver: a new transfer is offered only once the previous one has gone
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsp.push_back(predict_allocator_response(s_data));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // monitor
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_rsp.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (want.status < 5) status_seen[want.status]++;
                    check_field("status", want.status, m_data.status);
                    check_field("block_start", want.block_start, m_data.block_start);
                    check_field("block_bytes", want.block_bytes, m_data.block_bytes);
                    check_field("used_blocks", want.used_blocks, m_data.used_blocks);
                    check_field("used_bytes", want.used_bytes, m_data.used_bytes);
                    check_field("free_bytes", want.free_bytes, m_data.free_bytes);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_req(input logic [1:0] mode, input int unsigned req_sz,
                            input int unsigned ofs);
        req_t r;
        r.mode = mode;
        r.request_size = req_sz[SIZE_W-1:0];
        r.block_offset = ofs[OFS_W-1:0];
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || expected_rsp.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[SIZE_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_shadow[idx] = (idx == CFG_RES0_START || idx == CFG_RES1_START) ?
                          (val & 32'hF_FFFF) : (val & 32'h1F_FFFF);
    endtask

    task automatic set_pool(input int unsigned pool, input int unsigned st0,
                            input int unsigned sz0, input int unsigned st1,
                            input int unsigned sz1);
        wait_idle();
        write_cfg(CFG_POOL_SIZE, pool);
        write_cfg(CFG_RES0_START, st0);
        write_cfg(CFG_RES0_SIZE, sz0);
        write_cfg(CFG_RES1_START, st1);
        write_cfg(CFG_RES1_SIZE, sz1);
    endtask

    function automatic int unsigned pick_offset();
        int unsigned pool;
        pool = cfg_shadow[CFG_POOL_SIZE];
        if (live_starts.size() != 0 && $urandom_range(99) < 80)
            return live_starts[$urandom_range(live_starts.size() - 1)];
        if ($urandom_range(1)) return $urandom_range(pool) & 32'hFFFF_FFFC;
        return $urandom() & 32'hF_FFFF;
    endfunction

    task automatic run_random(input int n);
        int r, k;
        int unsigned sz;
        for (int i = 0; i < n; i++) begin
            // hand over one item at a time so offsets come from the live blocks
            while (pending_reqs.size() != 0) @(negedge aclk);
            r = $urandom_range(99);
            k = $urandom_range(9);
            sz = (k < 7) ? $urandom_range(64) :
                 (k < 9) ? $urandom_range(cfg_shadow[CFG_POOL_SIZE]) : ($urandom() & 32'h1F_FFFF);
            if (r < 3)
                push_req(MODE_INIT, $urandom(), $urandom());
            else if (r < 50)
                push_req(MODE_ALLOC, sz, $urandom());
            else if (r < 85)
                push_req(MODE_FREE, $urandom(), pick_offset());
            else
                push_req(MODE_GET, $urandom(), pick_offset());
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: uninitialised pool, bad configurations, then the edges of a good one
        push_req(MODE_ALLOC, 8, 0);
        push_req(MODE_FREE, 0, 0);
        push_req(MODE_GET, 0, 0);
        set_pool(0, 0, 0, 0, 0);
        push_req(MODE_INIT, 0, 0);
        set_pool(6, 0, 0, 0, 0);
        push_req(MODE_INIT, 0, 0);
        set_pool(2097151, 0, 0, 0, 0);
        push_req(MODE_INIT, 0, 0);
        set_pool(1048576, 3, 4, 0, 2097151);
        push_req(MODE_INIT, 0, 0);
        set_pool(1048576, 0, 8, 4, 8);
        push_req(MODE_INIT, 0, 0);
        set_pool(1048576, 0, 0, 1048572, 8);
        push_req(MODE_INIT, 0, 0);
        set_pool(1048576, 0, 16, 1048560, 16);
        push_req(MODE_INIT, 0, 0);
        push_req(MODE_ALLOC, 0, 0);
        push_req(MODE_ALLOC, 1048576, 0);
        push_req(MODE_ALLOC, 2097151, 0);
        push_req(MODE_ALLOC, 5, 0);
        push_req(MODE_FREE, 0, 3);
        push_req(MODE_FREE, 0, 0);
        push_req(MODE_GET, 0, 16);
        push_req(MODE_FREE, 0, 16);
        push_req(MODE_FREE, 0, 16);
        push_req(MODE_GET, 0, 1048575);
        push_req(MODE_ALLOC, 1048544, 0);

        // small pool filled with tiny blocks until the table is full
        set_pool(1024, 1048572, 0, 524288, 0);
        push_req(MODE_INIT, 0, 0);
        for (int i = 0; i < 66; i++) push_req(MODE_ALLOC, 4, 0);
        run_random(150);

        idle_pct = 74;
        set_pool(1048576, 4096, 1024, 1040384, 8192);
        push_req(MODE_INIT, 0, 0);
        run_random(100);
        // let everything drain before carrying on
        wait_idle();
        run_random(100);

        idle_pct = 0;
        stall_pct = 74;
        set_pool(256, 64, 32, 128, 128);
        push_req(MODE_INIT, 0, 0);
        run_random(200);

        idle_pct = 9;
        stall_pct = 9;
        set_pool(4, 0, 0, 0, 0);
        push_req(MODE_INIT, 0, 0);
        run_random(40);
        set_pool(1024, 0, 4, 1020, 4);
        push_req(MODE_INIT, 0, 0);
        for (int i = 0; i < 66; i++) push_req(MODE_ALLOC, 4, 0);
        run_random(120);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d transfers in, %0d results; peak region count %0d", items_sent,
                 results_seen, peak_regions);
        $display("Status tally ok/no space/bad offset/init error/table full: %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
        if (errors == 0 && expected_rsp.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
